/* sv/deq_pkg.sv */
// Shared types and constants for the double-ended queue.
// Holds request, status and cell operation codes; no dependencies.
package deq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int WORD_BITS_DEF  = 32;
	localparam int PORT_WORD_BITS = 32;
	localparam int COUNT_OUT_BITS = 5;

	typedef enum logic [1:0] {
		REQ_PUSH_LEFT  = 2'd0,
		REQ_PUSH_RIGHT = 2'd1,
		REQ_POP_LEFT   = 2'd2,
		REQ_POP_RIGHT  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Operation broadcast to every cell of the row.
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_PUSH_LEFT,
		OP_PUSH_RIGHT,
		OP_POP_LEFT,
		OP_POP_RIGHT
	} cell_op_t;

endpackage

/* sv/deq_cell.sv */
// One storage cell of the deque row: a word and its valid flag.
// Depends on deq_pkg for the cell operation codes.
module deq_cell import deq_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cell_op_t             op,
	input  logic [WORD_BITS-1:0] push_word,
	input  logic                 left_valid,
	input  logic [WORD_BITS-1:0] left_data,
	input  logic                 right_valid,
	input  logic [WORD_BITS-1:0] right_data,
	output logic                 valid,
	output logic [WORD_BITS-1:0] data,
	output logic [WORD_BITS-1:0] tail_data
);

	logic                 valid_q;
	logic [WORD_BITS-1:0] data_q;
	logic                 valid_d;
	logic [WORD_BITS-1:0] data_d;
	logic                 is_tail;

	assign is_tail = valid_q && !right_valid;

	always_comb begin
		valid_d = valid_q;
		data_d  = data_q;
		unique case (op)
			OP_HOLD: begin
			end
			OP_PUSH_LEFT: begin
				// take the neighbour's entry from the left
				valid_d = left_valid;
				data_d  = left_data;
			end
			OP_POP_LEFT: begin
				// take the neighbour's entry from the right
				valid_d = right_valid;
				data_d  = right_data;
			end
			OP_PUSH_RIGHT: begin
				// first free cell after the last entry captures the word
				if (!valid_q && left_valid) begin
					valid_d = 1'b1;
					data_d  = push_word;
				end
			end
			OP_POP_RIGHT: begin
				if (is_tail) begin
					valid_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign valid     = valid_q;
	assign data      = data_q;
	assign tail_data = is_tail ? data_q : '0;

endmodule

/* sv/double_ended_queue_core.sv */
// Top level of the double-ended queue: request decode, cell row, response register.
// Depends on deq_pkg and deq_cell.
//
// A bounded double-ended queue of signed words, built as a row of DEPTH cells.
// Entries are held left-justified: cell 0 holds the leftmost entry, and the
// entries occupy a contiguous run of cells from there. A push at the left end
// shifts the whole row one cell to the right, a pop at the left end shifts
// it one cell to the left; a push at the right end is caught by the first
// free cell, and a pop at the right end clears the last valid cell, whose
// word reaches the response through an AND-OR select over the row. Each
// request produces exactly one response, which is held in an output register
// until taken; req_ready is high whenever that register is empty or being
// drained, so one request per cycle is accepted while the response side
// keeps up. Throughput is set by the response register alone; the response
// appears in the cycle after its request is accepted.
// A push to a full deque is refused with status full, a pop from an empty
// deque with status empty; neither changes the contents, and both answer a
// popped word of zero, as does every successful push. fill_count reports the
// number of entries held after the request. Words wider than WORD_BITS keep
// their low bits on a push and are sign-extended back to 32 bits on a pop.
module double_ended_queue_core import deq_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic [1:0]                       req_type,
	input  logic signed [PORT_WORD_BITS-1:0] push_value,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output logic [1:0]                       status,
	output logic signed [PORT_WORD_BITS-1:0] pop_value,
	output logic [COUNT_OUT_BITS-1:0]        fill_count
);

	localparam int CNT_BITS = $clog2(DEPTH + 1);
	localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

	// occupancy, kept alongside the row so that full and empty are quick to decide
	logic [CNT_BITS-1:0]       count_q;
	logic [CNT_BITS-1:0]       count_d;

	// response register
	logic                      rsp_valid_q;
	status_t                   status_q;
	logic [PORT_WORD_BITS-1:0] pop_value_q;
	logic [COUNT_OUT_BITS-1:0] fill_count_q;

	logic                      accept;
	logic                      is_full;
	logic                      is_empty;
	req_t                      req;
	cell_op_t                  op;
	status_t                   status_d;
	logic                      pop_left;
	logic                      pop_right;

	logic [WORD_BITS-1:0]      push_word;
	logic [WORD_BITS-1:0]      head_word;
	logic [WORD_BITS-1:0]      tail_word;
	logic [WORD_BITS-1:0]      popped_word;
	logic [PORT_WORD_BITS-1:0] popped_out;
	logic [COUNT_OUT_BITS-1:0] count_out;

	logic                      cell_valid [DEPTH];
	logic [WORD_BITS-1:0]      cell_data  [DEPTH];
	logic [WORD_BITS-1:0]      cell_tail  [DEPTH];

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign req       = req_t'(req_type);
	assign is_full   = (count_q == CNT_FULL);
	assign is_empty  = (count_q == '0);

	// Narrow or widen the pushed word to the stored width.
	generate
		if (WORD_BITS <= PORT_WORD_BITS) begin : g_push_narrow
			assign push_word = push_value[WORD_BITS-1:0];
		end else begin : g_push_wide
			assign push_word = {{(WORD_BITS - PORT_WORD_BITS){push_value[PORT_WORD_BITS-1]}},
				push_value};
		end
	endgenerate

	// Decode the request into one row operation, and its status.
	always_comb begin
		op        = OP_HOLD;
		status_d  = ST_DONE;
		pop_left  = 1'b0;
		pop_right = 1'b0;
		count_d   = count_q;
		unique case (req)
			REQ_PUSH_LEFT, REQ_PUSH_RIGHT: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					op      = (req == REQ_PUSH_LEFT) ? OP_PUSH_LEFT : OP_PUSH_RIGHT;
					count_d = count_q + 1'b1;
				end
			end
			REQ_POP_LEFT, REQ_POP_RIGHT: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					pop_left  = (req == REQ_POP_LEFT);
					pop_right = (req == REQ_POP_RIGHT);
					op        = (req == REQ_POP_LEFT) ? OP_POP_LEFT : OP_POP_RIGHT;
					count_d   = count_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
		// no request this cycle: hold the row
		if (!accept) begin
			op = OP_HOLD;
		end
	end

	// Row of cells; each sees its two neighbours, the ends see fixed edges.
	generate
		for (genvar i = 0; i < DEPTH; i++) begin : g_cell
			logic                 lv;
			logic [WORD_BITS-1:0] ld;
			logic                 rv;
			logic [WORD_BITS-1:0] rd;

			if (i == 0) begin : g_left_edge
				assign lv = 1'b1;
				assign ld = push_word;
			end else begin : g_left_link
				assign lv = cell_valid[i-1];
				assign ld = cell_data[i-1];
			end

			if (i == DEPTH - 1) begin : g_right_edge
				assign rv = 1'b0;
				assign rd = '0;
			end else begin : g_right_link
				assign rv = cell_valid[i+1];
				assign rd = cell_data[i+1];
			end

			deq_cell #(
				.WORD_BITS (WORD_BITS)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.op          (op),
				.push_word   (push_word),
				.left_valid  (lv),
				.left_data   (ld),
				.right_valid (rv),
				.right_data  (rd),
				.valid       (cell_valid[i]),
				.data        (cell_data[i]),
				.tail_data   (cell_tail[i])
			);
		end
	endgenerate

	assign head_word = cell_data[0];

	// Only the last valid cell drives a non-zero tail word; merge them.
	always_comb begin
		tail_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tail_word = tail_word | cell_tail[i];
		end
	end

	always_comb begin
		popped_word = '0;
		if (pop_left) begin
			popped_word = head_word;
		end else if (pop_right) begin
			popped_word = tail_word;
		end
	end

	// Sign-extend or truncate the popped word to the port width.
	generate
		if (WORD_BITS >= PORT_WORD_BITS) begin : g_pop_narrow
			assign popped_out = popped_word[PORT_WORD_BITS-1:0];
		end else begin : g_pop_wide
			assign popped_out = {{(PORT_WORD_BITS - WORD_BITS){popped_word[WORD_BITS-1]}},
				popped_word};
		end
	endgenerate

	generate
		if (CNT_BITS >= COUNT_OUT_BITS) begin : g_cnt_trunc
			assign count_out = count_d[COUNT_OUT_BITS-1:0];
		end else begin : g_cnt_ext
			assign count_out = {{(COUNT_OUT_BITS - CNT_BITS){1'b0}}, count_d};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				// drop the response once taken
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q     <= status_d;
			pop_value_q  <= popped_out;
			fill_count_q <= count_out;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign pop_value  = pop_value_q;
	assign fill_count = fill_count_q;

endmodule

/* sv/deq_checker.sv */
// Port-level checks for the double-ended queue core, bound to its top level.
// Depends on deq_pkg for status codes and widths.
module deq_checker import deq_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_valid,
	input logic                             req_ready,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic [1:0]                       status,
	input logic signed [PORT_WORD_BITS-1:0] pop_value,
	input logic [COUNT_OUT_BITS-1:0]        fill_count
);

	localparam logic [COUNT_OUT_BITS-1:0] FULL_COUNT = COUNT_OUT_BITS'(DEPTH);

	// a refused request never returns a word
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_FULL || status == ST_EMPTY) |-> pop_value == '0)
		else $error("refused request returned a non-zero word");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EMPTY |-> fill_count == '0)
		else $error("empty refusal with non-zero count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> fill_count == FULL_COUNT)
		else $error("full refusal with count below depth");

	// an empty response register must never stall requests
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request stalled with no response pending");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(pop_value) && $stable(status))
		else $error("stalled response changed");

endmodule

bind double_ended_queue_core deq_checker #(
	.DEPTH     (DEPTH)
) u_deq_checker (.*);

/* tb/tb.sv */
// Self-checking testbench for the double-ended queue core.
// Depends on deq_pkg and double_ended_queue_core; runs directed and random requests
// against an in-bench model of the deque, with idling and stalls on both channels.
module tb;
	import deq_pkg::*;

	localparam int DEPTH       = DEPTH_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT    = 12;
	localparam int PRINT_CAP   = 40;

	// One expected response, held in request order.
	typedef struct packed {
		status_t                   st;
		logic [PORT_WORD_BITS-1:0] word;
		logic [COUNT_OUT_BITS-1:0] count;
	} deq_rsp_t;

	logic                             clk        = 1'b0;
	logic                             arst_n     = 1'b0;
	logic                             req_valid  = 1'b0;
	logic                             req_ready;
	logic [1:0]                       req_type   = REQ_PUSH_LEFT;
	logic signed [PORT_WORD_BITS-1:0] push_value = '0;
	logic                             rsp_valid;
	logic                             rsp_ready  = 1'b0;
	logic [1:0]                       status;
	logic signed [PORT_WORD_BITS-1:0] pop_value;
	logic [COUNT_OUT_BITS-1:0]        fill_count;

	// Shadow copy of the deque contents, kept as a circular buffer.
	logic [PORT_WORD_BITS-1:0] shadow_slot [DEPTH];
	int                        shadow_head  = 0;
	int                        shadow_count = 0;

	deq_rsp_t pending_responses[$];
	deq_rsp_t head_rsp;

	bit quiet        = 1'b0;   // set: neither side idles
	int mismatches   = 0;
	int cycle_count  = 0;
	int n_requests   = 0;
	int n_done       = 0;
	int n_full       = 0;
	int n_empty      = 0;
	int n_checked    = 0;

	double_ended_queue_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_type   (req_type),
		.push_value (push_value),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.status     (status),
		.pop_value  (pop_value),
		.fill_count (fill_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advance the shadow deque by one request and return the response it must give.
	function automatic deq_rsp_t predict_response(req_t r, logic [PORT_WORD_BITS-1:0] v);
		deq_rsp_t rsp;
		rsp.st   = ST_DONE;
		rsp.word = '0;
		case (r)
			REQ_PUSH_LEFT, REQ_PUSH_RIGHT: begin
				if (shadow_count >= DEPTH) begin
					rsp.st = ST_FULL;
				end else if (r == REQ_PUSH_LEFT) begin
					shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
					shadow_slot[shadow_head] = v;
					shadow_count++;
				end else begin
					shadow_slot[(shadow_head + shadow_count) % DEPTH] = v;
					shadow_count++;
				end
			end
			REQ_POP_LEFT: begin
				if (shadow_count == 0) begin
					rsp.st = ST_EMPTY;
				end else begin
					rsp.word    = shadow_slot[shadow_head];
					shadow_head = (shadow_head + 1) % DEPTH;
					shadow_count--;
				end
			end
			default: begin
				if (shadow_count == 0) begin
					rsp.st = ST_EMPTY;
				end else begin
					rsp.word = shadow_slot[(shadow_head + shadow_count - 1) % DEPTH];
					shadow_count--;
				end
			end
		endcase
		rsp.count = shadow_count[COUNT_OUT_BITS-1:0];
		return rsp;
	endfunction

	task automatic report_mismatch(input string what);
		if (mismatches < PRINT_CAP)
			$display("MISMATCH @%0t: %s", $realtime, what);
		mismatches++;
	endtask

	// Send one request: maybe idle first, then hold it until accepted and
	// record the response it must produce.
	task automatic send_request(input req_t r, input logic [PORT_WORD_BITS-1:0] v);
		deq_rsp_t rsp;
		if (!quiet && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid  <= 1'b1;
		req_type   <= r;
		push_value <= v;
		do @(posedge clk); while (!req_ready);
		rsp = predict_response(r, v);
		pending_responses.push_back(rsp);
		n_requests++;
		case (rsp.st)
			ST_DONE:  n_done++;
			ST_FULL:  n_full++;
			default:  n_empty++;
		endcase
	endtask

	// Hold off the sender until every outstanding response has been taken.
	task automatic drain_responses();
		req_valid <= 1'b0;
		while (pending_responses.size() != 0) @(posedge clk);
	endtask

	// Half the time a word extreme, otherwise any 32-bit value.
	function automatic logic [PORT_WORD_BITS-1:0] rand_word();
		case ($urandom_range(7))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'hFFFF_FFFF;
			3:       return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_refused_on_empty();
		send_request(REQ_POP_LEFT, 32'h1234_5678);
		send_request(REQ_POP_RIGHT, 32'hFFFF_FFFF);
	endtask

	// Empty the deque with its last pop, then check that it stays plainly empty.
	task automatic test_spent_deque();
		send_request(REQ_PUSH_LEFT, 32'hDEAD_BEEF);
		send_request(REQ_POP_LEFT, 32'h0);
		send_request(REQ_POP_RIGHT, 32'h0);
	endtask

	// Fill both ends up to DEPTH with extreme and patterned words, refuse two more, take one
	// from each end.
	task automatic test_fill_and_overflow();
		logic [PORT_WORD_BITS-1:0] fill_words [8];
		fill_words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'hFFFF_FFFE};
		for (int i = 0; i < DEPTH; i++)
			send_request((i % 2) ? REQ_PUSH_RIGHT : REQ_PUSH_LEFT, fill_words[i % 8]);
		send_request(REQ_PUSH_LEFT, 32'h0BAD_0BAD);
		send_request(REQ_PUSH_RIGHT, 32'hF00D_F00D);
		send_request(REQ_POP_LEFT, 32'h0);
		send_request(REQ_POP_RIGHT, 32'h0);
	endtask

	// Random traffic in windows that lean towards pushes, pops or neither, so the deque
	// swings between full and empty many times over.
	task automatic test_random_mix(input int n_items);
		int push_pct;
		int window;
		push_pct = 50;
		window   = 0;
		for (int i = 0; i < n_items; i++) begin
			if (window == 0) begin
				window = $urandom_range(10, 40);
				case ($urandom_range(2))
					0:       push_pct = 85;
					1:       push_pct = 15;
					default: push_pct = 50;
				endcase
			end
			window--;
			if ($urandom_range(99) < push_pct)
				send_request($urandom_range(1) ? REQ_PUSH_RIGHT : REQ_PUSH_LEFT, rand_word());
			else
				send_request($urandom_range(1) ? REQ_POP_RIGHT : REQ_POP_LEFT, $urandom);
		end
	endtask

	// Back-to-back requests with neither side idling.
	task automatic test_back_to_back(input int n_items);
		quiet = 1'b1;
		test_random_mix(n_items);
		drain_responses();
		quiet = 1'b0;
	endtask

	// Response side: stall at random, compare each taken response with the oldest
	// expected one.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (pending_responses.size() == 0) begin
					report_mismatch($sformatf("response with none expected: st=%0d val=%h cnt=%0d",
						status, pop_value, fill_count));
				end else begin
					head_rsp = pending_responses.pop_front();
					n_checked++;
					if (status !== head_rsp.st || pop_value !== head_rsp.word ||
							fill_count !== head_rsp.count)
						report_mismatch($sformatf(
							"response %0d: st=%0d/%0d val=%h/%h cnt=%0d/%0d (got/expected)",
							n_checked, status, head_rsp.st, pop_value, head_rsp.word,
							fill_count, head_rsp.count));
				end
			end
			rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog: drop the run if it overruns a generous cycle budget.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d responses outstanding",
				cycle_count, pending_responses.size());
			$display("** double_ended_queue_core: FAILED **");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_refused_on_empty();
		test_spent_deque();
		test_fill_and_overflow();
		// Let every directed response arrive before random traffic starts.
		drain_responses();
		test_random_mix(1500);
		drain_responses();
		test_back_to_back(350);

		req_valid <= 1'b0;
		while (pending_responses.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Ran %0d requests: %0d done, %0d refused full, %0d refused empty.",
			n_requests, n_done, n_full, n_empty);
		$display("Checked %0d responses with %0d mismatches.", n_checked, mismatches);
		if (mismatches == 0)
			$display("** double_ended_queue_core: PASSED **");
		else
			$display("** double_ended_queue_core: FAILED **");
		$finish;
	end

endmodule
